// File: rtl/integer_to_ascii_formatter_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the integer to ASCII formatter
// Shared property shapes used by the formatter's concurrent checks.
// ----------------------------------------------------------------------------
`ifndef INTEGER_TO_ASCII_FORMATTER_UNIT_MACROS_SVH
`define INTEGER_TO_ASCII_FORMATTER_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ITOA_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("formatter check failed");

// Next-cycle implication, checked outside reset.
`define ITOA_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("formatter check failed");

`endif

// File: rtl/itoa_fmt_pkg.sv
// ----------------------------------------------------------------------------
// Integer to ASCII formatter package
// Format codes, field widths, character constants and digit helpers.
// ----------------------------------------------------------------------------
package itoa_fmt_pkg;

  // Format selector codes.
  localparam logic [1:0] FMT_SDEC = 2'd0;
  localparam logic [1:0] FMT_UDEC = 2'd1;
  localparam logic [1:0] FMT_HEXL = 2'd2;
  localparam logic [1:0] FMT_HEXU = 2'd3;

  // Field and datapath widths.
  localparam int FUNC_W     = 2;
  localparam int VALUE_W    = 64;
  localparam int CHAR_W     = 8;
  localparam int DEC_W      = 32;
  localparam int BCD_DIGITS = 10;
  localparam int BCD_W      = 4 * BCD_DIGITS;
  localparam int HEX_DIGITS = VALUE_W / 4;
  localparam int REM_W      = $clog2(HEX_DIGITS + 1);
  localparam int CNT_W      = $clog2(DEC_W);

  // Character constants.
  localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'd48;
  localparam logic [CHAR_W-1:0] ASCII_MINUS = 8'd45;
  localparam logic [CHAR_W-1:0] ASCII_LOWER = 8'd87;  // 'a' minus ten
  localparam logic [CHAR_W-1:0] CASE_OFFSET = 8'd32;

  typedef logic [BCD_W-1:0] bcd_t;

  // One double-dabble step: add three to every digit of five or more.
  function automatic bcd_t bcd_adjust(input bcd_t bcd);
    bcd_t res;
    res = bcd;
    for (int i = 0; i < BCD_DIGITS; i++) begin
      if (bcd[4*i +: 4] >= 4'd5) begin
        res[4*i +: 4] = bcd[4*i +: 4] + 4'd3;
      end
    end
    return res;
  endfunction

  // True when every digit is a legal decimal digit.
  function automatic logic bcd_legal(input bcd_t bcd);
    logic ok;
    ok = 1'b1;
    for (int i = 0; i < BCD_DIGITS; i++) begin
      if (bcd[4*i +: 4] > 4'd9) begin
        ok = 1'b0;
      end
    end
    return ok;
  endfunction

  // ASCII glyph of one digit, letters in the chosen case.
  function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] d, input logic upper);
    logic [CHAR_W-1:0] c;
    if (d <= 4'd9) begin
      c = ASCII_ZERO + {4'd0, d};
    end else begin
      c = ASCII_LOWER + {4'd0, d};
      if (upper) begin
        c = c - CASE_OFFSET;
      end
    end
    return c;
  endfunction

endpackage

// File: rtl/integer_to_ascii_formatter_unit.sv
// Sequence: hex loads the value, skips each leading zero nibble, then emits the characters;
// decimal first runs a bit-serial binary to BCD conversion over the 32-bit word, then emits
// a minus sign if the value is negative, then the digits.
// Throughput: one number at a time; no new input is taken until its last character enters
// the output register, and a stalled output side holds the emission; the serial converter and the
// one-character output register set the pace. Reset (rst, synchronous) empties the output.
// ----------------------------------------------------------------------------
// Integer to ASCII formatter
// Converts one integer into signed/unsigned decimal or hex text, emitted one
// character word at a time, most significant first, with tlast on the end.
// ----------------------------------------------------------------------------
`include "integer_to_ascii_formatter_unit_macros.svh"

module integer_to_ascii_formatter_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // [63:0] value
  input  logic [1:0]  s_axis_tuser,   // [1:0] func
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] char_code
  output logic        m_axis_tlast
);

  // State codes.
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CONV = 2'd1;
  localparam logic [1:0] ST_SIGN = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  logic [1:0]                              state;
  logic [itoa_fmt_pkg::DEC_W-1:0]          bin;
  itoa_fmt_pkg::bcd_t                      bcd;
  itoa_fmt_pkg::bcd_t                      bcd_next;
  logic [itoa_fmt_pkg::CNT_W-1:0]          bit_cnt;
  logic [itoa_fmt_pkg::VALUE_W-1:0]        digs;
  logic [itoa_fmt_pkg::REM_W-1:0]          remaining;
  logic                                    started;
  logic                                    minus;
  logic                                    upper;
  logic                                    out_valid;
  logic [itoa_fmt_pkg::CHAR_W-1:0]         out_char;
  logic                                    out_last;
  logic                                    adv;
  logic                                    accept;
  logic                                    skip;
  logic                                    out_load;
  logic [3:0]                              top_digit;
  logic [itoa_fmt_pkg::DEC_W-1:0]          word;
  logic                                    word_neg;

  // Handshake and output register advance.
  assign s_axis_tready = (state == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign adv           = !out_valid || m_axis_tready;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_char;
  assign m_axis_tlast  = out_last;

  // Signed decimal input: sign and low word of the value.
  assign word     = s_axis_tdata[itoa_fmt_pkg::DEC_W-1:0];
  assign word_neg = (s_axis_tuser == itoa_fmt_pkg::FMT_SDEC) && word[itoa_fmt_pkg::DEC_W-1];

  // Double-dabble: correct the digits, then shift in the next binary bit.
  always_comb begin
    itoa_fmt_pkg::bcd_t adj;
    adj      = itoa_fmt_pkg::bcd_adjust(bcd);
    bcd_next = {adj[itoa_fmt_pkg::BCD_W-2:0], bin[itoa_fmt_pkg::DEC_W-1]};
  end

  // Leading zero digits are dropped until the first nonzero one or the last one.
  assign top_digit = digs[itoa_fmt_pkg::VALUE_W-1 -: 4];
  assign skip      = !started && (top_digit == 4'd0) && (remaining > 1);

  // A new character word enters the output register this cycle.
  assign out_load = (state == ST_SIGN && adv) || (state == ST_EMIT && !skip && adv);

  // Sequencer and datapath.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            started <= 1'b0;
            upper   <= (s_axis_tuser == itoa_fmt_pkg::FMT_HEXU);
            minus   <= word_neg;
            if (s_axis_tuser == itoa_fmt_pkg::FMT_HEXL ||
                s_axis_tuser == itoa_fmt_pkg::FMT_HEXU) begin
              digs      <= s_axis_tdata;
              remaining <= itoa_fmt_pkg::REM_W'(itoa_fmt_pkg::HEX_DIGITS);
              state     <= ST_EMIT;
            end else begin
              bin     <= word_neg ? (~word + 1'b1) : word;
              bcd     <= '0;
              bit_cnt <= itoa_fmt_pkg::CNT_W'(itoa_fmt_pkg::DEC_W - 1);
              state   <= ST_CONV;
            end
          end
        end
        ST_CONV: begin
          bcd     <= bcd_next;
          bin     <= {bin[itoa_fmt_pkg::DEC_W-2:0], 1'b0};
          bit_cnt <= bit_cnt - 1'b1;
          if (bit_cnt == '0) begin
            digs      <= {bcd_next, {(itoa_fmt_pkg::VALUE_W - itoa_fmt_pkg::BCD_W){1'b0}}};
            remaining <= itoa_fmt_pkg::REM_W'(itoa_fmt_pkg::BCD_DIGITS);
            state     <= minus ? ST_SIGN : ST_EMIT;
          end
        end
        ST_SIGN: begin
          if (adv) begin
            out_char  <= itoa_fmt_pkg::ASCII_MINUS;
            out_last  <= 1'b0;
            state     <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (skip) begin
            digs      <= {digs[itoa_fmt_pkg::VALUE_W-5:0], 4'd0};
            remaining <= remaining - 1'b1;
          end else if (adv) begin
            out_char  <= itoa_fmt_pkg::digit_char(top_digit, upper);
            out_last  <= (remaining == 1);
            started   <= 1'b1;
            digs      <= {digs[itoa_fmt_pkg::VALUE_W-5:0], 4'd0};
            remaining <= remaining - 1'b1;
            if (remaining == 1) begin
              state <= ST_IDLE;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Checks on the conversion and emission sequence.
  `ITOA_ASSERT_SAME(a_emit_nonempty, clk, rst, state == ST_EMIT, remaining != '0)
  `ITOA_ASSERT_SAME(a_bcd_legal, clk, rst, state == ST_CONV, itoa_fmt_pkg::bcd_legal(bcd))
  `ITOA_ASSERT_NEXT(a_hex_load, clk, rst,
    accept && s_axis_tuser[1], state == ST_EMIT && remaining == itoa_fmt_pkg::HEX_DIGITS)
  `ITOA_ASSERT_NEXT(a_last_ends, clk, rst,
    state == ST_EMIT && !skip && adv && remaining == 1,
    state == ST_IDLE && out_valid && out_last)
  `ITOA_ASSERT_NEXT(a_sign_first, clk, rst,
    state == ST_SIGN && adv, out_char == itoa_fmt_pkg::ASCII_MINUS && !out_last)

endmodule
